// File: rtl/core/dtts_pkg.sv
// Shared types and constants for the disk transfer track splitter.
// Used by dtts_div, disk_transfer_track_splitter and its testbench; depends on nothing.
`timescale 1ns / 1ps

package dtts_pkg;

    // Geometry
    localparam int DRIVES           = 4;
    localparam int BLOCKS_PER_TRACK = 20;
    localparam int TRACK_BYTES      = 10240;
    localparam int SECTOR_BYTES     = 256;
    localparam int LAST_TRACK       = 1023;
    localparam int MAX_RESULTS      = 16;

    // Field widths
    localparam int DRV_W    = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int BLOCK_W  = 15;
    localparam int BYTE_W   = 16;
    localparam int ADDR_W   = 22;
    localparam int TRACK_W  = 10;
    localparam int CYL_W    = TRACK_W - 1;
    localparam int DA_W     = 16;
    localparam int WC_W     = 13;
    localparam int SECT_SH  = $clog2(SECTOR_BYTES);

    // Divider widths
    localparam int QUOT_W   = $clog2((2**BLOCK_W - 1) / BLOCKS_PER_TRACK + 1);
    localparam int REM_W    = $clog2(BLOCKS_PER_TRACK + 1);

    // Reciprocal of BLOCKS_PER_TRACK, exact over the whole block range
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (2**RECIP_SH + BLOCKS_PER_TRACK - 1) / BLOCKS_PER_TRACK;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int PROD_W   = BLOCK_W + RECIP_W;

    // Working widths
    localparam int TRK_W    = $clog2((2**BLOCK_W - 1) / BLOCKS_PER_TRACK + MAX_RESULTS + 1);
    localparam int SECT_W   = REM_W + 1;
    localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        FUNC_XFER   = 2'd0,
        FUNC_POS    = 2'd1,
        FUNC_FORGET = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        KIND_SEEK     = 3'd0,
        KIND_XFER     = 3'd1,
        KIND_HDR      = 3'd2,
        KIND_POS      = 3'd3,
        KIND_PAST_END = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_XFER,
        ST_ACK
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } dtts_div_res_t;

endpackage

// File: rtl/core/disk_transfer_track_splitter.sv
// Disk transfer track splitter: request in, seek/transfer commands out.
// Sequence: track divide, then per part a seek check and a transfer step, each waiting
// for a free output register; the seek check may end the request with a header-needed
// or past-end result, and a position report or forget is acknowledged from ST_ACK.
// Flow: one transaction at a time; a new request is accepted only in the idle state.
// Reset: synchronous active-low aresetn clears the sequencer, output valid and all known bits.
`timescale 1ns / 1ps

module disk_transfer_track_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    // drive, block, byte_count, memory_address, is_read, header_track, zero pad
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,   // func
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_drive, seek_distance, seek_outward, head_select, disk_address,
    // word_count, out_address, out_read, zero pad
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import dtts_pkg::*;

    localparam logic [BYTE_W:0] TRACK_BYTES_W = (BYTE_W + 1)'(TRACK_BYTES);

    // Input fields
    logic [1:0]         in_drive;
    logic [BLOCK_W-1:0] in_block;
    logic [BYTE_W-1:0]  in_bytes;
    logic [ADDR_W-1:0]  in_addr;
    logic               in_read;
    logic [TRACK_W-1:0] in_hdr;
    logic               in_drive_ok;
    logic               accept;

    assign in_drive = s_tdata[1:0];
    assign in_block = s_tdata[16:2];
    assign in_bytes = s_tdata[32:17];
    assign in_addr  = s_tdata[54:33];
    assign in_read  = s_tdata[55];
    assign in_hdr   = s_tdata[65:56];
    assign in_drive_ok = {30'd0, in_drive} < DRIVES;

    state_t             state_reg, state_next;
    logic [DRV_W-1:0]   drive_reg, drive_next;
    logic [BYTE_W-1:0]  left_reg,  left_next;
    logic [ADDR_W-1:0]  addr_reg,  addr_next;
    logic               rd_reg,    rd_next;
    logic [TRK_W-1:0]   trk_reg,   trk_next;
    logic [SECT_W-1:0]  sect_reg,  sect_next;
    logic [BYTE_W-1:0]  room_reg,  room_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [DRIVES-1:0]  known_reg, known_next;

    // Output register
    logic               m_valid_reg, m_valid_next;
    kind_t              o_kind_reg,  o_kind_next;
    logic [DRV_W-1:0]   o_drive_reg, o_drive_next;
    logic [CYL_W-1:0]   o_dist_reg,  o_dist_next;
    logic               o_outw_reg,  o_outw_next;
    logic               o_head_reg,  o_head_next;
    logic [DA_W-1:0]    o_da_reg,    o_da_next;
    logic [WC_W-1:0]    o_wc_reg,    o_wc_next;
    logic [ADDR_W-1:0]  o_addr_reg,  o_addr_next;
    logic               o_rd_reg,    o_rd_next;
    logic               o_last_reg,  o_last_next;

    // Head position store (contents undefined until reported)
    logic [TRACK_W-1:0] head_mem [DRIVES];
    logic               ht_we;
    logic [DRV_W-1:0]   ht_wa;
    logic [TRACK_W-1:0] ht_wd;

    dtts_div_res_t      div_res;
    logic               div_start;

    // Datapath temporaries
    logic               out_free;
    logic [TRACK_W-1:0] cur_track;
    logic [CYL_W-1:0]   cur_cyl, tgt_cyl;
    logic               outward, need_seek;
    logic [BYTE_W:0]    off_w;
    logic [BYTE_W-1:0]  part, left_after;
    logic [CNT_W-1:0]   cnt_inc;
    logic               part_last;

    dtts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (in_block),
        .res      (div_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Seek arithmetic against the stored head position
    always_comb begin
        cur_track = head_mem[drive_reg];
        cur_cyl   = cur_track[TRACK_W-1:1];
        tgt_cyl   = trk_reg[TRACK_W-1:1];
        outward   = tgt_cyl > cur_cyl;
        need_seek = (cur_track != trk_reg[TRACK_W-1:0]);
        off_w     = (BYTE_W + 1)'(sect_reg) << SECT_SH;
        part      = (left_reg < room_reg) ? left_reg : room_reg;
        left_after = left_reg - part;
        cnt_inc   = cnt_reg + 1'b1;
        part_last = (left_after == '0) || (cnt_inc > CNT_W'(MAX_RESULTS - 2));
    end

    // Sequencer: next state and result generation
    always_comb begin
        state_next   = state_reg;
        drive_next   = drive_reg;
        left_next    = left_reg;
        addr_next    = addr_reg;
        rd_next      = rd_reg;
        trk_next     = trk_reg;
        sect_next    = sect_reg;
        room_next    = room_reg;
        cnt_next     = cnt_reg;
        known_next   = known_reg;
        div_start    = 1'b0;
        ht_we        = 1'b0;
        ht_wa        = drive_reg;
        ht_wd        = trk_reg[TRACK_W-1:0];

        m_valid_next = m_valid_reg && !m_tready;
        o_kind_next  = o_kind_reg;
        o_drive_next = o_drive_reg;
        o_dist_next  = o_dist_reg;
        o_outw_next  = o_outw_reg;
        o_head_next  = o_head_reg;
        o_da_next    = o_da_reg;
        o_wc_next    = o_wc_reg;
        o_addr_next  = o_addr_reg;
        o_rd_next    = o_rd_reg;
        o_last_next  = o_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && in_drive_ok) begin
                    drive_next = in_drive[DRV_W-1:0];
                    left_next  = in_bytes;
                    addr_next  = in_addr;
                    rd_next    = in_read;
                    cnt_next   = '0;
                    case (s_tuser)
                        FUNC_XFER: begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        FUNC_POS: begin
                            ht_we = 1'b1;
                            ht_wa = in_drive[DRV_W-1:0];
                            ht_wd = in_hdr;
                            known_next[in_drive[DRV_W-1:0]] = 1'b1;
                            state_next = ST_ACK;
                        end
                        FUNC_FORGET: begin
                            known_next[in_drive[DRV_W-1:0]] = 1'b0;
                            state_next = ST_ACK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    trk_next   = TRK_W'(div_res.quot);
                    sect_next  = {div_res.rem, 1'b0};
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    o_drive_next = drive_reg;
                    o_dist_next  = '0;
                    o_outw_next  = 1'b0;
                    o_head_next  = 1'b0;
                    o_da_next    = '0;
                    o_wc_next    = '0;
                    o_addr_next  = '0;
                    o_rd_next    = 1'b0;
                    o_last_next  = 1'b1;
                    room_next    = (TRACK_BYTES_W > off_w) ?
                                   BYTE_W'(TRACK_BYTES_W - off_w) : '0;
                    if (trk_reg > TRK_W'(LAST_TRACK)) begin
                        m_valid_next = 1'b1;
                        o_kind_next  = KIND_PAST_END;
                        state_next   = ST_IDLE;
                    end else if (!known_reg[drive_reg]) begin
                        m_valid_next = 1'b1;
                        o_kind_next  = KIND_HDR;
                        state_next   = ST_IDLE;
                    end else begin
                        if (need_seek) begin
                            m_valid_next = 1'b1;
                            o_kind_next  = KIND_SEEK;
                            o_dist_next  = outward ? (tgt_cyl - cur_cyl) : (cur_cyl - tgt_cyl);
                            o_outw_next  = outward;
                            o_head_next  = trk_reg[0];
                            o_last_next  = 1'b0;
                            ht_we        = 1'b1;
                            cnt_next     = cnt_inc;
                        end
                        state_next = ST_XFER;
                    end
                end
            end
            ST_XFER: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = KIND_XFER;
                    o_drive_next = drive_reg;
                    o_dist_next  = '0;
                    o_outw_next  = 1'b0;
                    o_head_next  = 1'b0;
                    o_da_next    = {trk_reg[TRACK_W-1:0], 6'(sect_reg)};
                    o_wc_next    = WC_W'(part >> 1);
                    o_addr_next  = addr_reg;
                    o_rd_next    = rd_reg;
                    o_last_next  = part_last;
                    left_next    = left_after;
                    addr_next    = addr_reg + ADDR_W'(part);
                    sect_next    = '0;
                    trk_next     = trk_reg + 1'b1;
                    cnt_next     = cnt_inc;
                    state_next   = part_last ? ST_IDLE : ST_CHECK;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = KIND_POS;
                    o_drive_next = drive_reg;
                    o_dist_next  = '0;
                    o_outw_next  = 1'b0;
                    o_head_next  = 1'b0;
                    o_da_next    = '0;
                    o_wc_next    = '0;
                    o_addr_next  = '0;
                    o_rd_next    = 1'b0;
                    o_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            known_reg   <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            known_reg   <= known_next;
            cnt_reg     <= cnt_next;
            drive_reg   <= drive_next;
            left_reg    <= left_next;
            addr_reg    <= addr_next;
            rd_reg      <= rd_next;
            trk_reg     <= trk_next;
            sect_reg    <= sect_next;
            room_reg    <= room_next;
            o_kind_reg  <= o_kind_next;
            o_drive_reg <= o_drive_next;
            o_dist_reg  <= o_dist_next;
            o_outw_reg  <= o_outw_next;
            o_head_reg  <= o_head_next;
            o_da_reg    <= o_da_next;
            o_wc_reg    <= o_wc_next;
            o_addr_reg  <= o_addr_next;
            o_rd_reg    <= o_rd_next;
            o_last_reg  <= o_last_next;
        end
    end

    // Head position store write
    always_ff @(posedge aclk) begin
        if (ht_we) begin
            head_mem[ht_wa] <= ht_wd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'd0, o_rd_reg, o_addr_reg, o_wc_reg, o_da_reg,
                       o_head_reg, o_outw_reg, o_dist_reg, 2'(o_drive_reg)};

`ifndef SYNTHESIS
    // Header-needed and past-end results always close the request
    a_stop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_HDR || m_tuser == KIND_PAST_END) |-> m_tlast)
        else $error("stop result without last");

    // A seek is always followed by its transfer
    a_seek_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SEEK) |-> !m_tlast)
        else $error("seek marked last");

    // A transfer part never exceeds one track
    a_part_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_XFER) |-> m_tdata[41:29] <= WC_W'(TRACK_BYTES / 2))
        else $error("transfer part beyond track");

    // Result count per request stays within bound
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("too many results for one request");
`endif

endmodule

// File: rtl/core/dtts_div.sv
// Track divider: block number by BLOCKS_PER_TRACK through a reciprocal multiply.
// Quotient and remainder are valid the cycle after start. Depends on dtts_pkg.
`timescale 1ns / 1ps

module dtts_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [dtts_pkg::BLOCK_W-1:0]   dividend,
    output dtts_pkg::dtts_div_res_t        res
);
    import dtts_pkg::*;

    localparam logic [PROD_W-1:0] RECIP_X = PROD_W'(RECIP);

    logic [QUOT_W-1:0]  quo_reg,  quo_next;
    logic [BLOCK_W-1:0] blk_reg,  blk_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  prod;
    logic [BLOCK_W-1:0] quot_x;

    // Quotient from the scaled reciprocal, captured at start
    always_comb begin
        prod      = PROD_W'(dividend) * RECIP_X;
        quo_next  = quo_reg;
        blk_next  = blk_reg;
        done_next = start;
        if (start) begin
            quo_next = prod[RECIP_SH +: QUOT_W];
            blk_next = dividend;
        end
    end

    // Remainder: block minus quotient times track length
    assign quot_x = BLOCK_W'(quo_reg) * BLOCK_W'(BLOCKS_PER_TRACK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            quo_reg  <= quo_next;
            blk_reg  <= blk_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = REM_W'(blk_reg - quot_x);

endmodule

// File: dv/disk_transfer_track_splitter_test.sv
// Self-checking testbench for disk_transfer_track_splitter: seek/transfer command stream.
// Depends on dtts_pkg and the splitter RTL; a scoreboard class tracks head positions.
`timescale 1ns / 1ps

module disk_transfer_track_splitter_test;

    import dtts_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         RAND_ITEMS  = 408;
    localparam int         CYCLE_LIMIT = 400_000;
    localparam int         DRAIN_WAIT  = 64;

    // One request as it travels on the input channel
    typedef struct packed {
        logic [1:0]         func;
        logic [DRV_W-1:0]   drive;
        logic [BLOCK_W-1:0] block;
        logic [BYTE_W-1:0]  count;
        logic [ADDR_W-1:0]  addr;
        logic               rd;
        logic [TRACK_W-1:0] hdr;
    } req_t;

    // One drive command as seen on the result channel
    typedef struct packed {
        kind_t              kind;
        logic [DRV_W-1:0]   drive;
        logic [CYL_W-1:0]   distance;
        logic               outward;
        logic               head_sel;
        logic [DA_W-1:0]    da;
        logic [WC_W-1:0]    wc;
        logic [ADDR_W-1:0]  addr;
        logic               rd;
        logic               is_last;
    } cmd_t;

    // Head-position tracker and queue of the drive commands still owed
    class cmd_scoreboard;
        logic [TRACK_W-1:0] pos_track [DRIVES];
        bit                 pos_known [DRIVES];
        cmd_t               owed_cmds [$];
        int                 errors;
        int                 n_requests;
        int                 n_checked;
        int                 n_kind [5];

        function new();
            foreach (pos_known[i]) begin
                pos_known[i] = 1'b0;
                pos_track[i] = '0;
            end
            errors = 0;
            n_requests = 0;
            n_checked = 0;
            foreach (n_kind[i]) n_kind[i] = 0;
        endfunction

        function int pending();
            return owed_cmds.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function cmd_t blank(kind_t k, logic [DRV_W-1:0] drv);
            cmd_t c;
            c = '0;
            c.kind = k;
            c.drive = drv;
            return c;
        endfunction

        function string fmt(cmd_t c);
            return $sformatf({"kind=%0d drv=%0d dist=%0d out=%0d hd=%0d ",
                              "da=%h wc=%0d addr=%h rd=%0d last=%0d"},
                             c.kind, c.drive, c.distance, c.outward, c.head_sel, c.da, c.wc,
                             c.addr, c.rd, c.is_last);
        endfunction

        // Work out the commands an accepted transaction causes
        function void note_request(req_t r);
            cmd_t              run [$];
            cmd_t              c;
            int                d, trk, sect, left, off, room, part, cur_cyl, tgt_cyl;
            logic [ADDR_W-1:0] a;
            d = r.drive;
            n_requests++;
            if (d >= DRIVES) return;
            if (r.func == FUNC_POS || r.func == FUNC_FORGET) begin
                if (r.func == FUNC_POS) begin
                    pos_track[d] = r.hdr;
                    pos_known[d] = 1'b1;
                end else begin
                    pos_known[d] = 1'b0;
                end
                run.push_back(blank(KIND_POS, r.drive));
            end else if (r.func == FUNC_XFER) begin
                trk  = r.block / BLOCKS_PER_TRACK;
                sect = (r.block % BLOCKS_PER_TRACK) * 2;
                left = r.count;
                a    = r.addr;
                while (run.size() <= MAX_RESULTS - 2) begin
                    if (trk > LAST_TRACK) begin
                        run.push_back(blank(KIND_PAST_END, r.drive));
                        break;
                    end
                    if (!pos_known[d]) begin
                        run.push_back(blank(KIND_HDR, r.drive));
                        break;
                    end
                    // seek when cylinder or head differs
                    cur_cyl = pos_track[d] >> 1;
                    tgt_cyl = trk >> 1;
                    if (cur_cyl != tgt_cyl || pos_track[d][0] != trk[0]) begin
                        c = blank(KIND_SEEK, r.drive);
                        c.outward  = tgt_cyl > cur_cyl;
                        c.distance = CYL_W'(c.outward ? tgt_cyl - cur_cyl : cur_cyl - tgt_cyl);
                        c.head_sel = trk[0];
                        run.push_back(c);
                        pos_track[d] = trk[TRACK_W-1:0];
                    end
                    // transfer part up to the end of this track
                    off  = sect * SECTOR_BYTES;
                    room = (TRACK_BYTES > off) ? TRACK_BYTES - off : 0;
                    part = (left < room) ? left : room;
                    c = blank(KIND_XFER, r.drive);
                    c.da   = DA_W'((trk << 6) | (sect & 63));
                    c.wc   = WC_W'(part >> 1);
                    c.addr = a;
                    c.rd   = r.rd;
                    run.push_back(c);
                    left -= part;
                    a    = a + ADDR_W'(part);
                    if (left == 0) break;
                    sect = 0;
                    trk++;
                end
            end
            if (run.size() > 0) begin
                run[run.size()-1].is_last = 1'b1;
                foreach (run[i]) owed_cmds.push_back(run[i]);
            end
        endfunction

        // Compare one accepted command with the oldest one owed
        task check_command(cmd_t got);
            cmd_t want;
            n_checked++;
            if (got.kind <= KIND_PAST_END) n_kind[got.kind]++;
            if (owed_cmds.size() == 0) begin
                report({"unexpected command: ", fmt(got)});
            end else begin
                want = owed_cmds.pop_front();
                if (got !== want)
                    report({"got ", fmt(got), " | want ", fmt(want)});
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    cmd_scoreboard sb = new();
    bit            steady = 1'b0;   // no idling on either side while set
    int            cycles = 0;

    disk_transfer_track_splitter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 23);
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        cmd_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind     = kind_t'(m_tuser);
            got.drive    = m_tdata[1:0];
            got.distance = m_tdata[10:2];
            got.outward  = m_tdata[11];
            got.head_sel = m_tdata[12];
            got.da       = m_tdata[28:13];
            got.wc       = m_tdata[41:29];
            got.addr     = m_tdata[63:42];
            got.rd       = m_tdata[64];
            got.is_last  = m_tlast;
            sb.check_command(got);
        end
    end

    function automatic req_t mk(logic [1:0] func, int drv, int blk, int cnt, int addr,
                                bit rd, int hdr);
        req_t r;
        r.func  = func;
        r.drive = DRV_W'(drv);
        r.block = BLOCK_W'(blk);
        r.count = BYTE_W'(cnt);
        r.addr  = ADDR_W'(addr);
        r.rd    = rd;
        r.hdr   = TRACK_W'(hdr);
        return r;
    endfunction

    // Mostly requests in range on tracked drives, some position traffic and noise
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.drive = DRV_W'($urandom_range(0, DRIVES - 1));
        r.block = BLOCK_W'($urandom);
        r.count = BYTE_W'($urandom);
        r.addr  = ADDR_W'($urandom);
        r.rd    = 1'($urandom);
        r.hdr   = TRACK_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)      r.func = FUNC_POS;
        else if (pick < 16) r.func = FUNC_FORGET;
        else if (pick < 19) r.func = FUNC_UNUSED;
        else                r.func = FUNC_XFER;
        pick = $urandom_range(0, 99);
        if (pick < 80)      r.block = BLOCK_W'($urandom_range(0, 20479));
        else if (pick < 92) r.block = BLOCK_W'($urandom_range(20380, 20479));
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.count = BYTE_W'($urandom_range(0, 2047));
        else if (pick < 80) r.count = BYTE_W'($urandom_range(0, 25000));
        return r;
    endfunction

    // Drive one transaction and wait for its handshake
    task automatic send_request(req_t r);
        if (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {6'b0, r.hdr, r.rd, r.addr, r.count, r.block, r.drive};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        req_t directed [$];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unknown position, and past end before any position is known
        directed.push_back(mk(FUNC_XFER, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_XFER, 1, 32767, 65535, 'h3FFFFF, 1, 1023));
        directed.push_back(mk(FUNC_POS, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_POS, 1, 0, 0, 0, 0, 1023));
        directed.push_back(mk(FUNC_POS, 2, 0, 0, 0, 0, 2));
        directed.push_back(mk(FUNC_POS, 3, 0, 0, 0, 0, 513));
        // zero count, no seek
        directed.push_back(mk(FUNC_XFER, 0, 0, 0, 0, 0, 0));
        // head change only
        directed.push_back(mk(FUNC_XFER, 0, 20, 512, 'h1000, 1, 0));
        // full-size run with a seek per track and address wrap, odd count
        directed.push_back(mk(FUNC_XFER, 0, 0, 65535, 'h3FFFF0, 1, 0));
        // last track then past end mid-request
        directed.push_back(mk(FUNC_XFER, 1, 20479, 65535, 'h3FFFFF, 1, 0));
        // last sector, odd count
        directed.push_back(mk(FUNC_XFER, 2, 19, 1001, 'h2AAAAA, 0, 0));
        // long outward seek, then the longest inward seek
        directed.push_back(mk(FUNC_XFER, 3, 20460, 10240, 'h155555, 1, 0));
        directed.push_back(mk(FUNC_XFER, 3, 0, 1, 'h000001, 0, 0));
        // forget, then a request needing the header
        directed.push_back(mk(FUNC_FORGET, 3, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_XFER, 3, 100, 300, 0, 1, 0));
        // ignored function code
        directed.push_back(mk(FUNC_UNUSED, 2, 32767, 65535, 'h3FFFFF, 1, 1023));
        directed.push_back(mk(FUNC_POS, 2, 0, 0, 0, 0, 1023));
        directed.push_back(mk(FUNC_XFER, 2, 40, 20480, 'h155555, 0, 0));
        // past end on a known drive
        directed.push_back(mk(FUNC_XFER, 0, 32767, 100, 0, 0, 0));
        directed.push_back(mk(FUNC_XFER, 1, 10000, 10240, 'h2AAAAA, 1, 0));
        directed.push_back(mk(FUNC_POS, 3, 0, 0, 0, 0, 'h2AA));
        directed.push_back(mk(FUNC_XFER, 3, 16384, 40000, 'h0F0F0F, 1, 0));
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            steady = (i >= 150 && i < 230);
            // hold off until every owed command is back
            if (i == 300) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_drained();
            end
            send_request(random_request());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected commands never arrived", sb.pending()));

        $display("Sent %0d transactions, checked %0d commands over %0d cycles",
                 sb.n_requests, sb.n_checked, cycles);
        $display("Seeks %0d, transfers %0d, header requests %0d, position acks %0d, %s %0d",
                 sb.n_kind[KIND_SEEK], sb.n_kind[KIND_XFER], sb.n_kind[KIND_HDR],
                 sb.n_kind[KIND_POS], "past end", sb.n_kind[KIND_PAST_END]);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
